// File: hdl/upd_pkg.sv
package upd_pkg;

    // Characters that take part in escape decoding.
    localparam logic [7:0] CHAR_PCT     = 8'h25;
    localparam logic [7:0] CHAR_LOWER_U = 8'h75;
    localparam logic [7:0] CHAR_UPPER_U = 8'h55;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_QUEST   = 8'h3F;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;

    // The longest escape (percent, u, four hex digits) spans six bytes.
    localparam int WIN_DEPTH = 6;
    localparam int CNT_W     = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } upd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       suspicious;
        logic       end_of_string;
    } upd_out_t;

    // One input byte together with its classification.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
        logic       is_pct;
        logic       is_u;
        logic       is_zero;
        logic       is_hex;
        logic       is_special;
        logic [3:0] nibble;
    } upd_entry_t;

    localparam int ENTRY_W = $bits(upd_entry_t);

    // Head of the classified-byte queue as seen by the decoder.
    typedef struct packed {
        logic       valid;
        upd_entry_t entry;
    } upd_q_head_t;

    // Decoder window status, used for checking at the top level.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             fin;
    } upd_status_t;

endpackage

// File: hdl/upd_front.sv
module upd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              src_valid,
    output logic              src_ready,
    input  upd_pkg::upd_in_t  src_data,
    input  logic              q_full,
    output logic              q_push,
    output upd_pkg::upd_entry_t q_entry
);

    logic       replace_plus_reg;
    logic [7:0] ch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replace_plus_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            replace_plus_reg <= cfg_wdata;
        end
    end

    assign src_ready = !q_full;
    assign q_push    = src_valid && !q_full;

    // When replace_plus is set, plus is turned into a space before any classification.
    assign ch = (replace_plus_reg && src_data.in_byte == upd_pkg::CHAR_PLUS) ?
                upd_pkg::CHAR_SPACE : src_data.in_byte;

    always_comb
    begin
        q_entry.char_code  = ch;
        q_entry.last       = src_data.last_byte;
        q_entry.is_pct     = (ch == upd_pkg::CHAR_PCT);
        q_entry.is_u       = (ch == upd_pkg::CHAR_LOWER_U) || (ch == upd_pkg::CHAR_UPPER_U);
        q_entry.is_zero    = (ch == upd_pkg::CHAR_ZERO);
        q_entry.is_hex     = ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        q_entry.is_special = ch inside {upd_pkg::CHAR_SPACE, upd_pkg::CHAR_QUOTE,
                                        upd_pkg::CHAR_PCT, upd_pkg::CHAR_AMP,
                                        upd_pkg::CHAR_QUEST, upd_pkg::CHAR_SLASH};
        if (ch[6])
        begin
            q_entry.nibble = ch[3:0] + 4'd9;
        end
        else
        begin
            q_entry.nibble = ch[3:0];
        end
    end

endmodule

// File: hdl/upd_fifo.sv
module upd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  upd_pkg::upd_entry_t   push_entry,
    output logic                  full,
    input  logic                  pop,
    output upd_pkg::upd_q_head_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_pkg::upd_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/upd_back.sv
module upd_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  upd_pkg::upd_q_head_t  q_head,
    output logic                  q_pop,
    output logic                  dst_valid,
    input  logic                  dst_ready,
    output upd_pkg::upd_out_t     dst_data,
    output upd_pkg::upd_status_t  status
);

    localparam int WD = upd_pkg::WIN_DEPTH;
    localparam int CW = upd_pkg::CNT_W;

    upd_pkg::upd_entry_t [WD-1:0] win_reg, win_next, win_shift;
    logic [CW-1:0]                count_reg, count_next, n_after;
    logic                         fin_reg, fin_next;
    logic                         susp_reg, susp_next;
    logic                         out_valid_reg, out_valid_next;
    upd_pkg::upd_out_t            out_word_reg, out_word_next;

    logic [WD-1:0] av;
    logic          bad_u;
    logic          dec_ready, emit, suppress;
    logic [CW-1:0] used;
    logic [7:0]    ob;
    logic          final_dec, produce, take, consume, pull;

    // Decide the item at the head of the window.
    always_comb
    begin
        for (int k = 0; k < WD; k++)
        begin
            av[k] = (count_reg > CW'(k));
        end
        bad_u = 1'b0;
        for (int k = 2; k < WD; k++)
        begin
            bad_u = bad_u | (av[k] && !win_reg[k].is_hex);
        end

        dec_ready = 1'b0;
        emit      = 1'b0;
        suppress  = 1'b0;
        used      = CW'(1);
        ob        = upd_pkg::CHAR_PCT;

        if (count_reg != '0)
        begin
            dec_ready = 1'b1;
            emit      = 1'b1;
            if (!win_reg[0].is_pct)
            begin
                ob = win_reg[0].char_code;
            end
            else if (!av[1])
            begin
                if (!fin_reg)
                begin
                    dec_ready = 1'b0;
                end
            end
            else if (win_reg[1].is_u)
            begin
                if (!fin_reg && !av[5] && !bad_u)
                begin
                    dec_ready = 1'b0;
                end
                else if (av[5] && !bad_u)
                begin
                    used = CW'(6);
                    if (win_reg[2].is_zero && win_reg[3].is_zero)
                    begin
                        ob = {win_reg[4].nibble, win_reg[5].nibble};
                    end
                    else
                    begin
                        emit     = 1'b0;
                        suppress = 1'b1;
                    end
                end
                else if (av[2] && win_reg[2].is_special)
                begin
                    ob   = win_reg[2].char_code;
                    used = CW'(3);
                end
            end
            else
            begin
                if (win_reg[1].is_hex && !av[2] && !fin_reg)
                begin
                    dec_ready = 1'b0;
                end
                else if (win_reg[1].is_hex && av[2] && win_reg[2].is_hex)
                begin
                    ob   = {win_reg[1].nibble, win_reg[2].nibble};
                    used = CW'(3);
                end
                else if (win_reg[1].is_special)
                begin
                    ob   = win_reg[1].char_code;
                    used = CW'(2);
                end
            end
        end
    end

    assign final_dec = fin_reg && (count_reg == used);
    assign produce   = emit || final_dec;
    assign take      = !out_valid_reg || dst_ready;
    assign consume   = dec_ready && (!produce || take);
    assign n_after   = consume ? (count_reg - used) : count_reg;
    assign pull      = q_head.valid &&
                       (fin_reg ? (consume && final_dec) : (n_after < CW'(WD)));
    assign q_pop     = pull;

    always_comb
    begin
        win_shift = win_reg >> (int'(used) * upd_pkg::ENTRY_W);
        win_next  = consume ? win_shift : win_reg;
        if (pull)
        begin
            win_next[n_after] = q_head.entry;
        end
        count_next = n_after + CW'(pull);

        fin_next = fin_reg;
        if (consume && final_dec)
        begin
            fin_next = 1'b0;
        end
        if (pull && q_head.entry.last)
        begin
            fin_next = 1'b1;
        end

        susp_next = susp_reg;
        if (consume && final_dec)
        begin
            susp_next = 1'b0;
        end
        else if (consume && suppress)
        begin
            susp_next = 1'b1;
        end

        out_valid_next = out_valid_reg && !dst_ready;
        out_word_next  = out_word_reg;
        if (consume && produce)
        begin
            out_valid_next               = 1'b1;
            out_word_next.out_byte       = emit ? ob : 8'h00;
            out_word_next.byte_valid     = emit;
            out_word_next.suspicious     = final_dec && (susp_reg || suppress);
            out_word_next.end_of_string  = final_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            susp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fin_reg       <= fin_next;
            susp_reg      <= susp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        out_word_reg <= out_word_next;
    end

    assign dst_valid    = out_valid_reg;
    assign dst_data     = out_word_reg;
    assign status.count = count_reg;
    assign status.fin   = fin_reg;

endmodule

// File: hdl/url_percent_decoder_core.sv
// A byte that decides at once (plain character) passes through the queue, the decoder window
// and the output register; escape bytes wait in the decoder window until the escape is settled.
// Within a string the core takes one input byte per cycle while the queue has room.
// At the end of a string the window drains one word per cycle while the output is ready,
// before the next string enters, so a flush of up to six words can stall a back-to-back
// source once the queue (default depth four) fills, even when the output never stalls.
// Reset: asynchronous, active low; empties the queue and window, clears the suspicious flag,
// and sets replace_plus to 1.
module url_percent_decoder_core
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              src_valid,
    output logic              src_ready,
    input  upd_pkg::upd_in_t  src_data,
    output logic              dst_valid,
    input  logic              dst_ready,
    output upd_pkg::upd_out_t dst_data
);

    // The front end takes one word per cycle while the queue is not full, applies
    // the plus-to-space rule and classifies the byte (percent, u, zero, hex digit
    // with its value, special). Classified bytes wait in a short queue so that the
    // decoder can stall on its output or spend extra cycles on an end-of-string
    // flush without backing up the source immediately.
    upd_pkg::upd_entry_t  q_entry;
    logic                 q_push;
    logic                 q_full;
    upd_pkg::upd_q_head_t q_head;
    logic                 q_pop;
    upd_pkg::upd_status_t back_status;

    upd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    upd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    // The back end keeps a six-byte window. Each cycle it decides the item at the
    // head of the window (one output word, a suppressed %u escape, or a wait for
    // more bytes) and in the same cycle pulls the next byte from the queue when the
    // window has room. It never pulls past the final byte of a string, so the
    // end-of-string decision only ever sees bytes of the current string.
    upd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .status    (back_status)
    );

    // The suspicious flag is only ever reported on the final word of a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.suspicious |-> dst_data.end_of_string)
        else $error("suspicious flag on a word that does not end the string");

    // A word without a character is the bare end marker and carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_data.byte_valid |-> dst_data.end_of_string &&
        dst_data.out_byte == 8'h00)
        else $error("empty word that is not a clean end marker");

    // The window never overfills, and a pending end of string always has bytes left.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.count <= 3'd6 && (!back_status.fin || back_status.count != 3'd0))
        else $error("decoder window count out of range");

endmodule
